>>> rtl/bbt_pkg.sv
// Shared types and constants of the band tracker.
// No dependencies; every other file of the block imports it.
package bbt_pkg;

    localparam int PRICE_W = 24;
    localparam int CNT_W   = 9;
    localparam int MULT_W  = 12;
    localparam int SUM_W   = 32;
    localparam int SQ_W    = 56;
    localparam int UPPER_W = 26;
    localparam int LOWER_W = 27;
    localparam int Z_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MULTIPLIER = 2'd1;

    localparam logic [CNT_W-1:0]  WINDOW_LENGTH_RST   = 9'd20;
    localparam logic [MULT_W-1:0] BAND_MULTIPLIER_RST = 12'd512;

    // Shared serial divider: 64-bit dividend, 24-bit divisor.
    localparam int DIV_W  = 64;
    localparam int DVS_W  = 24;
    localparam int STEP_W = 7;

    typedef struct packed {
        logic               full;
        logic [CNT_W-1:0]   count;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sumsq;
        logic [PRICE_W-1:0] latest;
    } job_t;

endpackage

>>> rtl/bbt_if.sv
// Channel interfaces of the band tracker: sample input, result output, config write.
// Depends on bbt_pkg.
interface bbt_in_if;
    import bbt_pkg::*;
    logic               valid;
    logic               ready;
    logic               func;
    logic [PRICE_W-1:0] price;
    modport source (output valid, func, price, input ready);
    modport sink   (input valid, func, price, output ready);
endinterface

interface bbt_out_if;
    import bbt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      window_full;
    logic [PRICE_W-1:0]        band_middle;
    logic [PRICE_W-1:0]        deviation;
    logic [UPPER_W-1:0]        band_upper;
    logic signed [LOWER_W-1:0] band_lower;
    logic signed [Z_W-1:0]     zscore_below;
    modport source (output valid, window_full, band_middle, deviation, band_upper,
                    band_lower, zscore_below, input ready);
    modport sink   (input valid, window_full, band_middle, deviation, band_upper,
                    band_lower, zscore_below, output ready);
endinterface

interface bbt_cfg_if;
    import bbt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bollinger_band_tracker_top.sv
// Top level of the Bollinger band tracker: config registers, front end, queue, back end.
// Depends on bbt_pkg, bbt_if, bbt_front, bbt_queue, bbt_back.
//
// Usage:
//   samples : valid/ready channel; func 0 pushes price, func 1 clears the window.
//   results : valid/ready channel; one result beat per sample beat, in order.
//   cfg     : valid/ready write channel, always ready; index 0 window_length,
//             index 1 band_multiplier. Write only while the block is idle.
// Sequence: the front end handles an add beat as ring read, squares, sum update and
//   queue push; a clear goes straight to the queue push. The back end runs a
//   full-window add through variance division, square root, mean division, bands and
//   z-score division; the three divisions share one serial divider. A partial window
//   skips the mean, bands and z-score, and a clear skips all of these steps. Sustained
//   throughput is set by that back-end sequence.
// A two-entry job queue lets the front end accept new beats while the back end
//   works or while a finished result waits in the output register.
// Reset: empties the window, sums, queue and output; window_length returns to 20,
//   band_multiplier to 2.0. The ring storage itself is not cleared.
// Stall: a stalled receiver holds the result register; the back end then waits,
//   the queue fills, and samples.ready drops until space frees up.
module bollinger_band_tracker_top #(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    bbt_in_if.sink     samples,
    bbt_out_if.source  results,
    bbt_cfg_if.sink    cfg
);
    import bbt_pkg::*;

    logic [CNT_W-1:0]  window_length_reg;
    logic [MULT_W-1:0] band_multiplier_reg;
    logic [CNT_W-1:0]  win_len;

    job_t job;
    job_t q_data;
    logic job_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Config port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg   <= WINDOW_LENGTH_RST;
            band_multiplier_reg <= BAND_MULTIPLIER_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WINDOW_LENGTH:   window_length_reg   <= cfg.data[CNT_W-1:0];
                CFG_BAND_MULTIPLIER: band_multiplier_reg <= cfg.data[MULT_W-1:0];
                default:             window_length_reg   <= window_length_reg;
            endcase
        end
    end

    // Clamp the window length into 1 .. MAX_WINDOW.
    always_comb
    begin
        priority if (window_length_reg == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if (window_length_reg > CNT_W'(MAX_WINDOW))
        begin
            win_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_len = window_length_reg;
        end
    end

    bbt_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .win_len  (win_len),
        .job_push (job_push),
        .job      (job),
        .q_full   (q_full)
    );

    bbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    bbt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .win_len   (win_len),
        .band_mult (band_multiplier_reg),
        .results   (results)
    );

    // Hold off the front end while the queue is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into a full queue");

    // An accepted beat keeps the front end busy for the next cycle.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("front end accepted back-to-back beats");

    // Bands stay zero until the window is full.
    a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.window_full) |->
        (results.band_middle == '0 && results.band_upper == '0 &&
         results.band_lower == '0 && results.zscore_below == '0))
        else $error("nonzero band on a partial window");

    // Zero deviation drops the z-score.
    a_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.deviation == '0) |-> (results.zscore_below == '0))
        else $error("z-score with zero deviation");

endmodule

>>> rtl/bbt_front.sv
// Front end: accepts beats, keeps the sample ring and the running sums, emits jobs.
// Depends on bbt_pkg and bbt_if.
module bbt_front #(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    bbt_in_if.sink                 samples,
    input  logic [bbt_pkg::CNT_W-1:0] win_len,
    output logic                   job_push,
    output bbt_pkg::job_t          job,
    input  logic                   q_full
);
    import bbt_pkg::*;

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADDR_W = SLOT_W + 2;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_READ = 4'b0010,
        F_UPD  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [PRICE_BITS-1:0]   ring [MAX_WINDOW];
    logic [PRICE_BITS-1:0]   rd_data_reg;
    logic [SLOT_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       old_sum;

    logic [SLOT_W-1:0]       slot_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         sumsq_reg;
    logic [PRICE_W-1:0]      latest_reg;

    logic [PRICE_BITS-1:0]   p_reg;
    logic                    evict_reg;
    logic [PRICE_BITS-1:0]   e_reg;
    logic [2*PRICE_BITS-1:0] esq_reg;
    logic [2*PRICE_BITS-1:0] psq_reg;

    logic                    accept;

    assign samples.ready = (state_reg == F_IDLE);
    assign accept        = samples.valid && samples.ready;

    // Oldest slot: write_slot minus count, modulo the ring depth.
    assign old_sum = ADDR_W'(slot_reg) + ADDR_W'(MAX_WINDOW) - ADDR_W'(count_reg);
    assign rd_addr = (old_sum >= ADDR_W'(MAX_WINDOW)) ?
                     SLOT_W'(old_sum - ADDR_W'(MAX_WINDOW)) : SLOT_W'(old_sum);

    always_ff @(posedge clk)
    begin
        if (state_reg == F_UPD)
        begin
            ring[slot_reg] <= p_reg;
        end
        rd_data_reg <= ring[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = samples.func ? F_PUSH : F_READ;
                end
            end
            F_READ: state_next = F_UPD;
            F_UPD:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            slot_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            sumsq_reg  <= '0;
            latest_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (samples.func)
                begin
                    slot_reg   <= '0;
                    count_reg  <= '0;
                    sum_reg    <= '0;
                    sumsq_reg  <= '0;
                    latest_reg <= '0;
                end
                else
                begin
                    latest_reg <= PRICE_W'(samples.price[PRICE_BITS-1:0]);
                end
            end
            if (state_reg == F_UPD)
            begin
                sum_reg   <= sum_reg - SUM_W'(e_reg) + SUM_W'(p_reg);
                sumsq_reg <= sumsq_reg - SQ_W'(esq_reg) + SQ_W'(psq_reg);
                count_reg <= evict_reg ? count_reg : count_reg + CNT_W'(1);
                slot_reg  <= (slot_reg == SLOT_W'(MAX_WINDOW - 1)) ?
                             '0 : slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg     <= samples.price[PRICE_BITS-1:0];
            evict_reg <= (count_reg >= win_len);
        end
        if (state_reg == F_READ)
        begin
            e_reg   <= evict_reg ? rd_data_reg : '0;
            esq_reg <= evict_reg ? rd_data_reg * rd_data_reg : '0;
            psq_reg <= p_reg * p_reg;
        end
    end

    assign job_push   = (state_reg == F_PUSH) && !q_full;
    assign job.full   = (count_reg == win_len);
    assign job.count  = count_reg;
    assign job.sum    = sum_reg;
    assign job.sumsq  = sumsq_reg;
    assign job.latest = latest_reg;

endmodule

>>> rtl/bbt_queue.sv
// Two-entry job queue between front and back end.
// Depends on bbt_pkg.
module bbt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bbt_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output bbt_pkg::job_t pop_data,
    output logic          empty
);
    import bbt_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> rtl/bbt_divider.sv
// Restoring serial divider, one quotient bit a cycle.
// Depends on bbt_pkg. The dividend comes in left-aligned to the step count.
module bbt_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bbt_pkg::DIV_W-1:0]   dividend,
    input  logic [bbt_pkg::DVS_W-1:0]   divisor,
    input  logic [bbt_pkg::STEP_W-1:0]  steps,
    output logic                        done,
    output logic [bbt_pkg::DIV_W-1:0]   quotient
);
    import bbt_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic              ge;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
        end
    end

endmodule

>>> rtl/bbt_back.sv
// Back end: turns a job into deviation, bands and z-score; holds the result register.
// Depends on bbt_pkg, bbt_if and bbt_divider.
module bbt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  bbt_pkg::job_t               q_data,
    output logic                        q_pop,
    input  logic [bbt_pkg::CNT_W-1:0]   win_len,
    input  logic [bbt_pkg::MULT_W-1:0]  band_mult,
    bbt_out_if.source                   results
);
    import bbt_pkg::*;

    typedef enum logic [12:0] {
        B_IDLE      = 13'b0000000000001,
        B_MUL       = 13'b0000000000010,
        B_DIFF      = 13'b0000000000100,
        B_VAR_GO    = 13'b0000000001000,
        B_VAR_WAIT  = 13'b0000000010000,
        B_SQRT      = 13'b0000000100000,
        B_MEAN_GO   = 13'b0000001000000,
        B_MEAN_WAIT = 13'b0000010000000,
        B_MD        = 13'b0000100000000,
        B_BAND      = 13'b0001000000000,
        B_Z_GO      = 13'b0010000000000,
        B_Z_WAIT    = 13'b0100000000000,
        B_OUT       = 13'b1000000000000
    } bstate_t;

    localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;
    localparam logic [36:0] Z_POS_MAX = 37'd32767;
    localparam logic [36:0] Z_NEG_MAX = 37'd32768;

    localparam logic signed [LOWER_W-1:0] LOWER_FLOOR = {1'b1, {(LOWER_W-1){1'b0}}};
    localparam logic signed [Z_W-1:0]     Z_FLOOR     = {1'b1, {(Z_W-1){1'b0}}};
    localparam logic signed [Z_W-1:0]     Z_CEIL      = {1'b0, {(Z_W-1){1'b1}}};

    bstate_t state_reg, state_next;

    job_t                      job_reg;
    logic [36:0]               pp_lo_reg;
    logic [36:0]               pp_hi_reg;
    logic [63:0]               sq_sum_reg;
    logic [17:0]               nn_reg;
    logic [63:0]               diff_reg;
    logic [63:0]               sq_v_reg;
    logic [63:0]               sq_r_reg;
    logic [63:0]               sq_bit_reg;
    logic [4:0]                sq_cnt_reg;
    logic [PRICE_W-1:0]        dev_reg;
    logic [PRICE_W-1:0]        middle_reg;
    logic [27:0]               md_reg;
    logic [UPPER_W-1:0]        upper_reg;
    logic signed [LOWER_W-1:0] lower_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic                      neg_reg;
    logic                      out_valid_reg;

    logic [63:0]               a_val;
    logic [63:0]               sq_t;
    logic                      sq_ge;
    logic [63:0]               sq_r_next;
    logic [28:0]               upper_sum;
    logic signed [29:0]        lower_val;
    logic signed [27:0]        z_diff;
    logic [27:0]               z_mag;
    logic [36:0]               z_q;
    logic                      out_load;

    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic [STEP_W-1:0]         div_steps;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quot;

    bbt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quot)
    );

    // n * sumsq modulo 2^64 from two 28-bit halves.
    assign a_val = 64'(pp_lo_reg) + 64'({pp_hi_reg, 28'b0});

    assign sq_t      = sq_r_reg + sq_bit_reg;
    assign sq_ge     = (sq_v_reg >= sq_t);
    assign sq_r_next = sq_ge ? (sq_r_reg >> 1) + sq_bit_reg : (sq_r_reg >> 1);

    assign upper_sum = 29'(middle_reg) + 29'(md_reg);
    assign lower_val = $signed(30'(middle_reg)) - $signed(30'(md_reg));

    assign z_diff = 28'(lower_reg) - $signed(28'(job_reg.latest));
    assign z_mag  = z_diff[27] ? 28'(-z_diff) : 28'(z_diff);
    assign z_q    = div_quot[36:0];

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_load = (state_reg == B_OUT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
        unique case (state_reg)
            B_VAR_GO:
            begin
                div_start    = 1'b1;
                div_dividend = diff_reg;
                div_divisor  = DVS_W'(nn_reg);
                div_steps    = STEP_W'(64);
            end
            B_MEAN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {job_reg.sum, 32'b0};
                div_divisor  = DVS_W'(win_len);
                div_steps    = STEP_W'(32);
            end
            B_Z_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {z_mag, 8'b0, 28'b0};
                div_divisor  = dev_reg;
                div_steps    = STEP_W'(36);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:      if (!q_empty) state_next = B_MUL;
            B_MUL:       state_next = B_DIFF;
            B_DIFF:      state_next = (job_reg.count == '0) ? B_OUT : B_VAR_GO;
            B_VAR_GO:    state_next = B_VAR_WAIT;
            B_VAR_WAIT:  if (div_done) state_next = B_SQRT;
            B_SQRT:
            begin
                if (sq_cnt_reg == '0)
                begin
                    state_next = job_reg.full ? B_MEAN_GO : B_OUT;
                end
            end
            B_MEAN_GO:   state_next = B_MEAN_WAIT;
            B_MEAN_WAIT: if (div_done) state_next = B_MD;
            B_MD:        state_next = B_BAND;
            B_BAND:      state_next = (dev_reg == '0) ? B_OUT : B_Z_GO;
            B_Z_GO:      state_next = B_Z_WAIT;
            B_Z_WAIT:    if (div_done) state_next = B_OUT;
            B_OUT:       if (out_load) state_next = B_IDLE;
            default:     state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg    <= q_data;
                dev_reg    <= '0;
                middle_reg <= '0;
                upper_reg  <= '0;
                lower_reg  <= '0;
                z_reg      <= '0;
            end
            B_MUL:
            begin
                pp_lo_reg  <= job_reg.count * job_reg.sumsq[27:0];
                pp_hi_reg  <= job_reg.count * job_reg.sumsq[55:28];
                sq_sum_reg <= job_reg.sum * job_reg.sum;
                nn_reg     <= job_reg.count * job_reg.count;
            end
            B_DIFF:
            begin
                diff_reg <= (a_val > sq_sum_reg) ? a_val - sq_sum_reg : '0;
            end
            B_VAR_WAIT:
            begin
                sq_v_reg   <= div_quot;
                sq_r_reg   <= '0;
                sq_bit_reg <= SQRT_TOP;
                sq_cnt_reg <= 5'd31;
            end
            B_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_v_reg <= sq_v_reg - sq_t;
                end
                sq_r_reg   <= sq_r_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
                if (sq_cnt_reg == '0)
                begin
                    dev_reg <= sq_r_next[PRICE_W-1:0];
                end
            end
            B_MEAN_WAIT:
            begin
                middle_reg <= div_quot[PRICE_W-1:0];
            end
            B_MD:
            begin
                md_reg <= 28'((36'(band_mult) * 36'(dev_reg)) >> 8);
            end
            B_BAND:
            begin
                upper_reg <= upper_sum[28:26] != '0 ? '1 : upper_sum[UPPER_W-1:0];
                lower_reg <= (lower_val < -30'sd67108864) ?
                             LOWER_FLOOR : $signed(lower_val[LOWER_W-1:0]);
            end
            B_Z_GO:
            begin
                neg_reg <= z_diff[27];
            end
            B_Z_WAIT:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        z_reg <= (z_q > Z_NEG_MAX) ? Z_FLOOR : -$signed(z_q[15:0]);
                    end
                    else
                    begin
                        z_reg <= (z_q > Z_POS_MAX) ? Z_CEIL : $signed(z_q[15:0]);
                    end
                end
            end
            default:
            begin
                sq_cnt_reg <= sq_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            results.window_full  <= job_reg.full;
            results.band_middle  <= middle_reg;
            results.deviation    <= dev_reg;
            results.band_upper   <= upper_reg;
            results.band_lower   <= lower_reg;
            results.zscore_below <= z_reg;
        end
    end

    assign results.valid = out_valid_reg;

endmodule
